[rtl/core/assert_macros.svh]
// Assertion macros shared by the divider and top-level RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define RCSG_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Condition never holds outside reset.
`define RCSG_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");
`else
`define RCSG_PROP(lbl, clk, rst_n, prop)
`define RCSG_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/core/rcsg_pkg.sv]
`default_nettype none
package rcsg_pkg;
	localparam int TIME_WIDTH_DEF = 48;
	localparam int FRAC_BITS_DEF = 14;

	// Q30 magnitudes, 1.0 = 2^30, need 31 bits
	localparam int QW = 31;
	localparam logic [QW-1:0] Q30_ONE = 31'h4000_0000;

	localparam logic [15:0] BOUND_099 = 16'd32440;
	localparam logic [15:0] BOUND_ONE = 16'd32768;

	localparam logic [7:0] CFG_DEADZONE = 8'd0;
	localparam logic [7:0] CFG_EXPO = 8'd1;
	localparam logic [7:0] CFG_SUPEREXPO = 8'd2;
	localparam logic [7:0] CFG_GAIN = 8'd3;
	localparam logic [7:0] CFG_TIMEOUT = 8'd4;
	localparam logic [7:0] CFG_ENABLE = 8'd5;
	localparam logic [7:0] CFG_MANUAL = 8'd6;
	localparam logic [7:0] CFG_RC_SRC = 8'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GATE,
		ST_DZ,
		ST_DIV1,
		ST_DIV1_W,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_ADD,
		ST_M5,
		ST_M6,
		ST_DIV2,
		ST_DIV2_W,
		ST_M7,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic [QW-1:0] num;
		logic [QW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [QW-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic ok;
		logic neg;
		logic [QW-1:0] mag;
	} gate_t;
endpackage
`default_nettype wire

[rtl/core/rcsg_serdiv.sv]
`default_nettype none
`include "assert_macros.svh"
// Restoring divider, one quotient bit per cycle: quo = (num << 30) / den.
// Caller guarantees num <= den, so the quotient fits 31 bits.
module rcsg_serdiv
	import rcsg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [QW-1:0] den_q;
	logic [QW:0]   trial;
	logic [QW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[QW-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits below the initial remainder shift through quo_q ahead of the quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num[QW-1:1]};
			quo_q <= {req.num[0], {(QW-1){1'b0}}};
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[QW-1:0] : trial[QW-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

	`RCSG_NEVER(a_no_restart, clk, arst_n, busy_q && req.start)
	`RCSG_PROP(a_start_busy, clk, arst_n, req.start |=> busy_q)
	`RCSG_PROP(a_done_idle, clk, arst_n, done_q |-> !busy_q)
endmodule
`default_nettype wire

[rtl/core/rcsg_gate.sv]
`default_nettype none
// Request gating checks and yaw magnitude in Q30.
module rcsg_gate
	import rcsg_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic [TIME_WIDTH-1:0] now_time,
	input  wire logic [TIME_WIDTH-1:0] mode_time,
	input  wire logic [7:0]            mode_source,
	input  wire logic [4:0]            mode_flags,
	input  wire logic [1:0]            rc_flags,
	input  wire logic [7:0]            rc_source,
	input  wire logic [TIME_WIDTH-1:0] rc_time,
	input  wire logic [TIME_WIDTH-1:0] rc_sample_time,
	input  wire logic signed [15:0]    throttle,
	input  wire logic signed [15:0]    yaw,
	input  wire logic                  requests_enabled,
	input  wire logic [31:0]           mode_timeout_us,
	input  wire logic [7:0]            manual_nav_code,
	input  wire logic [7:0]            rc_source_code,
	output gate_t                      gate
);
	localparam int SH = 30 - FRAC_BITS;
	localparam logic signed [31:0] STICK_ONE = 32'sd1 <<< FRAC_BITS;

	logic                  mode_ok;
	logic                  rc_ok;
	logic                  sticks_ok;
	logic [TIME_WIDTH-1:0] mode_age;
	logic signed [31:0]    thr_x;
	logic signed [31:0]    yaw_x;
	logic [16:0]           yaw_abs;

	assign mode_age = now_time - mode_time;
	assign thr_x = 32'(throttle);
	assign yaw_x = 32'(yaw);
	assign yaw_abs = yaw[15] ? 17'(-yaw_x) : 17'(yaw_x);

	assign mode_ok = mode_flags[0] && (mode_time != '0) && (mode_time <= now_time)
		&& (mode_age <= TIME_WIDTH'(mode_timeout_us)) && (mode_source == manual_nav_code)
		&& mode_flags[1] && (mode_flags[4:2] == 3'b000);

	assign sticks_ok = (thr_x >= -STICK_ONE) && (thr_x <= STICK_ONE)
		&& (yaw_x >= -STICK_ONE) && (yaw_x <= STICK_ONE);

	assign rc_ok = rc_flags[0] && rc_flags[1] && (rc_source == rc_source_code)
		&& (rc_time != '0) && (rc_sample_time != '0) && (rc_sample_time <= rc_time)
		&& (rc_time <= now_time) && sticks_ok;

	assign gate.ok = requests_enabled && mode_ok && rc_ok;
	assign gate.neg = yaw[15];
	assign gate.mag = {{(QW-17){1'b0}}, yaw_abs} << SH;
endmodule
`default_nettype wire

[rtl/core/rc_stick_shaping_request_gate.sv]
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      one stick and mode snapshot
// m_axis    out  m_axis_tvalid/tready      one gated steering request
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// An item gated off or inside the deadzone skips to the output step, else it
// runs two 31-step bit-serial divisions plus seven shared multiplier steps.
// The next snapshot is accepted once the sequencer is back in idle, while the
// previous result may still wait in the output register.
// Reset is asynchronous, active low; configuration takes reset values.
// A stalled output holds the sequencer in its final step.
`default_nettype none
`include "assert_macros.svh"
module rc_stick_shaping_request_gate
	import rcsg_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int IN_BITS = 4 * TIME_WIDTH + 55,
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = TIME_WIDTH + 65,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	// now_time, mode_time, mode_source, mode_flags, rc_flags, rc_source,
	// rc_time, rc_sample_time, throttle, yaw
	input  wire logic [IN_W-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	// request_valid, longitudinal, steering, sequence_res, sample_time
	output logic [OUT_W-1:0]     m_axis_tdata,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [7:0]      cfg_index,
	input  wire logic [31:0]     cfg_data
);
	localparam int T = TIME_WIDTH;
	localparam int SH = 30 - FRAC_BITS;
	localparam int O_MT = T;
	localparam int O_MS = 2 * T;
	localparam int O_MF = 2 * T + 8;
	localparam int O_RF = 2 * T + 13;
	localparam int O_RS = 2 * T + 15;
	localparam int O_RT = 2 * T + 23;
	localparam int O_RST = 3 * T + 23;
	localparam int O_THR = 4 * T + 23;
	localparam int O_YAW = 4 * T + 39;

	state_t state_q, state_d;

	logic [IN_W-1:0]  in_q;
	logic [15:0]      dz_q, expo_q, sexp_q, gain_q;
	logic [31:0]      timeout_q;
	logic             enable_q;
	logic [7:0]       manual_q, rcsrc_q;
	logic [31:0]      seq_q;
	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	gate_t            gate, gate_q;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	logic [QW-1:0]    w_bnd, e_bnd, s_bnd;
	logic [QW-1:0]    m1_q, c1_q, c_q, v_q, n_q, d_q, y_q;
	logic [2*QW-1:0]  t_q, p_q;
	logic [QW-1:0]    mul_a, mul_b;
	logic [2*QW-1:0]  mul_p;
	logic [2*QW-1:0]  sum;
	logic [46:0]      g;
	logic [QW-1:0]    gsat;
	logic [QW-1:0]    r;
	logic [15:0]      r16;
	logic [15:0]      steer;
	logic [15:0]      lon;
	logic [31:0]      seq_next;
	logic [OUT_BITS-1:0] out_bits;
	logic             out_free;
	logic             dz_zero;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

	assign w_bnd = {(dz_q > BOUND_099 ? BOUND_099 : dz_q), 15'd0};
	assign e_bnd = {(expo_q > BOUND_ONE ? BOUND_ONE : expo_q), 15'd0};
	assign s_bnd = {(sexp_q > BOUND_099 ? BOUND_099 : sexp_q), 15'd0};

	rcsg_gate #(
		.TIME_WIDTH(TIME_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_gate (
		.now_time(in_q[0 +: T]),
		.mode_time(in_q[O_MT +: T]),
		.mode_source(in_q[O_MS +: 8]),
		.mode_flags(in_q[O_MF +: 5]),
		.rc_flags(in_q[O_RF +: 2]),
		.rc_source(in_q[O_RS +: 8]),
		.rc_time(in_q[O_RT +: T]),
		.rc_sample_time(in_q[O_RST +: T]),
		.throttle(in_q[O_THR +: 16]),
		.yaw(in_q[O_YAW +: 16]),
		.requests_enabled(enable_q),
		.mode_timeout_us(timeout_q),
		.manual_nav_code(manual_q),
		.rc_source_code(rcsrc_q),
		.gate(gate)
	);

	rcsg_serdiv u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign mul_p = {{QW{1'b0}}, mul_a} * {{QW{1'b0}}, mul_b};
	assign sum = t_q + p_q;
	assign g = mul_p[61:15];
	assign gsat = (g > {16'd0, Q30_ONE}) ? Q30_ONE : g[QW-1:0];
	assign dz_zero = !gate_q.ok || (gate_q.mag <= w_bnd);
	assign out_free = !m_valid_q || m_axis_tready;

	assign r = y_q >> SH;
	assign r16 = r[15:0];
	assign steer = gate_q.ok ? (gate_q.neg ? 16'(-r16) : r16) : 16'd0;
	assign lon = gate_q.ok ? in_q[O_THR +: 16] : 16'd0;
	assign seq_next = seq_q + 32'd1;
	assign out_bits = {in_q[O_RST +: T], seq_next, steer, lon, gate_q.ok};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_GATE;
			ST_GATE:   state_d = ST_DZ;
			ST_DZ:     state_d = dz_zero ? ST_DONE : ST_DIV1;
			ST_DIV1:   state_d = ST_DIV1_W;
			ST_DIV1_W: if (div_rsp.done) state_d = ST_M1;
			ST_M1:     state_d = ST_M2;
			ST_M2:     state_d = ST_M3;
			ST_M3:     state_d = ST_M4;
			ST_M4:     state_d = ST_ADD;
			ST_ADD:    state_d = ST_M5;
			ST_M5:     state_d = ST_M6;
			ST_M6:     state_d = ST_DIV2;
			ST_DIV2:   state_d = ST_DIV2_W;
			ST_DIV2_W: if (div_rsp.done) state_d = ST_M7;
			ST_M7:     state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_req = '0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DIV1: begin
				div_req.start = 1'b1;
				div_req.num = gate_q.mag - w_bnd;
				div_req.den = Q30_ONE - w_bnd;
			end
			ST_DIV2: begin
				div_req.start = 1'b1;
				div_req.num = n_q;
				div_req.den = d_q;
			end
			ST_M1: begin
				mul_a = m1_q;
				mul_b = m1_q;
			end
			ST_M2: begin
				mul_a = c1_q;
				mul_b = m1_q;
			end
			ST_M3: begin
				mul_a = Q30_ONE - e_bnd;
				mul_b = m1_q;
			end
			ST_M4: begin
				mul_a = e_bnd;
				mul_b = c_q;
			end
			ST_M5: begin
				mul_a = v_q;
				mul_b = Q30_ONE - s_bnd;
			end
			ST_M6: begin
				mul_a = m1_q;
				mul_b = s_bnd;
			end
			ST_M7: begin
				mul_a = y_q;
				mul_b = {{(QW-16){1'b0}}, gain_q};
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_valid_q <= 1'b0;
			seq_q <= '0;
			dz_q <= '0;
			expo_q <= '0;
			sexp_q <= '0;
			gain_q <= '0;
			timeout_q <= 32'd500000;
			enable_q <= 1'b0;
			manual_q <= 8'd0;
			rcsrc_q <= 8'd1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
				seq_q <= seq_next;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_DEADZONE:  dz_q <= cfg_data[15:0];
					CFG_EXPO:      expo_q <= cfg_data[15:0];
					CFG_SUPEREXPO: sexp_q <= cfg_data[15:0];
					CFG_GAIN:      gain_q <= cfg_data[15:0];
					CFG_TIMEOUT:   timeout_q <= cfg_data;
					CFG_ENABLE:    enable_q <= cfg_data[0];
					CFG_MANUAL:    manual_q <= cfg_data[7:0];
					CFG_RC_SRC:    rcsrc_q <= cfg_data[7:0];
					default:       ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) in_q <= s_axis_tdata;
		if (state_q == ST_DONE && out_free) m_data_q <= OUT_W'(out_bits);
		unique case (state_q)
			ST_GATE:   gate_q <= gate;
			ST_DZ:     if (dz_zero) y_q <= '0;
			ST_DIV1_W: if (div_rsp.done) m1_q <= (div_rsp.quo > Q30_ONE) ? Q30_ONE : div_rsp.quo;
			ST_M1:     c1_q <= mul_p[60:30];
			ST_M2:     c_q <= mul_p[60:30];
			ST_M3:     t_q <= mul_p;
			ST_M4:     p_q <= mul_p;
			ST_ADD:    v_q <= sum[60:30];
			ST_M5:     n_q <= mul_p[60:30];
			ST_M6:     d_q <= Q30_ONE - mul_p[60:30];
			ST_DIV2_W: if (div_rsp.done) y_q <= div_rsp.quo;
			ST_M7:     y_q <= gsat;
			default:   ;
		endcase
	end

	`RCSG_PROP(a_invalid_zero, clk, arst_n, (m_valid_q && !m_data_q[0]) |-> (m_data_q[32:1] == 32'd0))
	`RCSG_PROP(a_seq_moves, clk, arst_n, $rose(m_valid_q) |-> (seq_q != $past(seq_q)))
	`RCSG_PROP(a_div_waited, clk, arst_n, div_rsp.done |-> (state_q == ST_DIV1_W || state_q == ST_DIV2_W))
endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
module testbench;
	import rcsg_pkg::*;

	localparam int TW = 48;
	localparam int FB = 14;
	localparam int IN_W = ((4 * TW + 55 + 7) / 8) * 8;
	localparam int OUT_W = ((TW + 65 + 7) / 8) * 8;
	localparam logic [63:0] ONE30 = 64'd1 << 30;
	localparam logic [4:0] MF_PRESENT = 5'h01, MF_MANUAL = 5'h02;
	localparam logic [1:0] RF_OK = 2'h3;

	typedef struct {
		logic [TW-1:0] now_t, mode_t;
		logic [7:0] msrc;
		logic [4:0] mflags;
		logic [1:0] rflags;
		logic [7:0] rsrc;
		logic [TW-1:0] rc_t, rc_sample_t;
		logic signed [15:0] thr, yaw;
	} snap_t;

	typedef struct {
		logic ok;
		logic [15:0] lon, steer;
		logic [31:0] seq;
		logic [TW-1:0] st;
	} request_t;

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid, m_axis_tready = 0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_valid = 0, cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// shadow registers
	logic [15:0] dz_w, expo_a, sexpo_a, gain;
	logic [31:0] tmo;
	logic enab;
	logic [7:0] manual_code, rc_code;
	logic [31:0] seq_cnt;

	request_t pending_requests[$];
	int errors = 0;
	int snd_idle = 0, rcv_idle = 0;

	rc_stick_shaping_request_gate i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#100_000_000;
		$display("rc_stick_shaping_request_gate: mismatch");
		$finish;
	end

	function automatic logic [63:0] bnd(logic [15:0] v, logic [15:0] hi);
		return (v > hi) ? 64'(hi) : 64'(v);
	endfunction

	function automatic logic [63:0] shape_yaw(logic [63:0] m);
		logic [63:0] w, e, s, c, v, n, d, y;
		w = bnd(dz_w, BOUND_099) << 15;
		e = bnd(expo_a, BOUND_ONE) << 15;
		s = bnd(sexpo_a, BOUND_099) << 15;
		if (m <= w)
			return 0;
		m = ((m - w) << 30) / (ONE30 - w);
		if (m > ONE30)
			m = ONE30;
		c = (((m * m) >> 30) * m) >> 30;
		v = ((ONE30 - e) * m + e * c) >> 30;
		n = (v * (ONE30 - s)) >> 30;
		d = ONE30 - ((m * s) >> 30);
		y = (n << 30) / d;
		y = (y * 64'(gain)) >> 15;
		if (y > ONE30)
			y = ONE30;
		return y;
	endfunction

	function automatic request_t predict_request(snap_t x);
		request_t r;
		logic mode_ok, rc_ok;
		logic signed [31:0] one;
		logic [63:0] mag, q;
		one = 32'sd1 <<< FB;
		mode_ok = x.mflags[0] && x.mode_t != 0 && x.mode_t <= x.now_t
			&& (x.now_t - x.mode_t) <= TW'(tmo) && x.msrc == manual_code
			&& x.mflags[1] && x.mflags[4:2] == 0;
		rc_ok = x.rflags[0] && x.rflags[1] && x.rsrc == rc_code && x.rc_t != 0
			&& x.rc_sample_t != 0 && x.rc_sample_t <= x.rc_t && x.rc_t <= x.now_t
			&& 32'(x.thr) >= -one && 32'(x.thr) <= one
			&& 32'(x.yaw) >= -one && 32'(x.yaw) <= one;
		seq_cnt = seq_cnt + 1;
		r.ok = enab && mode_ok && rc_ok;
		r.lon = 0;
		r.steer = 0;
		if (r.ok) begin
			mag = 64'(x.yaw < 0 ? -32'(x.yaw) : 32'(x.yaw)) << (30 - FB);
			q = shape_yaw(mag) >> (30 - FB);
			r.lon = x.thr;
			r.steer = x.yaw < 0 ? -16'(q) : 16'(q);
		end
		r.seq = seq_cnt;
		r.st = x.rc_sample_t;
		return r;
	endfunction

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			CFG_DEADZONE: dz_w = val[15:0];
			CFG_EXPO: expo_a = val[15:0];
			CFG_SUPEREXPO: sexpo_a = val[15:0];
			CFG_GAIN: gain = val[15:0];
			CFG_TIMEOUT: tmo = val;
			CFG_ENABLE: enab = val[0];
			CFG_MANUAL: manual_code = val[7:0];
			CFG_RC_SRC: rc_code = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_snap(snap_t x);
		request_t r;
		while ($urandom_range(99) < snd_idle)
			@(posedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata <= IN_W'({x.yaw, x.thr, x.rc_sample_t, x.rc_t, x.rsrc, x.rflags,
			x.mflags, x.msrc, x.mode_t, x.now_t});
		do @(posedge clk); while (!s_axis_tready);
		r = predict_request(x);
		pending_requests.push_back(r);
		s_axis_tvalid <= 0;
		@(posedge clk);
	endtask

	// receiver and checker
	always @(posedge clk) begin
		request_t e, a;
		if (m_axis_tvalid && m_axis_tready) begin
			{a.st, a.seq, a.steer, a.lon, a.ok} = m_axis_tdata[TW+64:0];
			if (pending_requests.size() == 0) begin
				$display("%0t unexpected transaction %h", $time, m_axis_tdata);
				errors++;
			end else begin
				e = pending_requests.pop_front();
				if (a.ok !== e.ok || a.lon !== e.lon || a.steer !== e.steer
					|| a.seq !== e.seq || a.st !== e.st) begin
					$display("%0t exp ok=%0d lon=%0d steer=%0d seq=%0d st=%0d",
						$time, e.ok, $signed(e.lon), $signed(e.steer), e.seq, e.st);
					$display("%0t got ok=%0d lon=%0d steer=%0d seq=%0d st=%0d",
						$time, a.ok, $signed(a.lon), $signed(a.steer), a.seq, a.st);
					errors++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= rcv_idle);
	end

	// well-formed snapshot; fields then perturbed by caller
	function automatic snap_t good_snap(logic signed [15:0] thr, logic signed [15:0] yaw);
		snap_t x;
		x.now_t = TW'({$urandom, $urandom}) | 48'h1_0000_0000;
		x.mode_t = x.now_t - $urandom_range(tmo > 1000 ? 1000 : tmo);
		x.msrc = manual_code;
		x.mflags = MF_PRESENT | MF_MANUAL;
		x.rflags = RF_OK;
		x.rsrc = rc_code;
		x.rc_t = x.now_t - $urandom_range(5000);
		x.rc_sample_t = x.rc_t - $urandom_range(5000);
		x.thr = thr;
		x.yaw = yaw;
		return x;
	endfunction

	function automatic logic signed [15:0] stick();
		int k;
		k = $urandom_range(9);
		if (k == 0)
			return 16'($urandom);
		if (k == 1)
			return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	function automatic snap_t random_snap();
		snap_t x;
		x = good_snap(stick(), stick());
		if ($urandom_range(99) < 25) begin
			case ($urandom_range(9))
				0: x.mflags = 5'($urandom);
				1: x.rflags = 2'($urandom);
				2: x.msrc = 8'($urandom);
				3: x.rsrc = 8'($urandom);
				4: x.mode_t = $urandom_range(1) ? '0 : x.now_t + 1;
				5: x.mode_t = x.now_t - TW'(tmo) - $urandom_range(1);
				6: x.rc_t = $urandom_range(1) ? '0 : x.now_t + $urandom_range(1, 9);
				7: x.rc_sample_t = $urandom_range(1) ? '0 : x.rc_t + 1;
				8: x.now_t = TW'({$urandom, $urandom});
				default: begin
					x.mode_t = TW'({$urandom, $urandom});
					x.rc_t = TW'({$urandom, $urandom});
					x.rc_sample_t = TW'({$urandom, $urandom});
				end
			endcase
		end
		return x;
	endfunction

	task automatic drain();
		int n;
		n = 0;
		while (pending_requests.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic random_config();
		write_reg(CFG_DEADZONE, $urandom_range(3) == 0 ? 32'($urandom_range(32440, 65535))
			: 32'($urandom_range(8000)));
		write_reg(CFG_EXPO, $urandom_range(3) == 0 ? 32'hFFFF : 32'($urandom_range(32768)));
		write_reg(CFG_SUPEREXPO, $urandom_range(3) == 0 ? 32'hFFFF
			: 32'($urandom_range(32768)));
		write_reg(CFG_GAIN, $urandom_range(3) == 0 ? 32'hFFFF : 32'($urandom_range(65535)));
		write_reg(CFG_TIMEOUT, $urandom_range(3) == 0 ? 32'hFFFF_FFFF
			: 32'($urandom_range(100000)));
		write_reg(CFG_MANUAL, $urandom);
		write_reg(CFG_RC_SRC, $urandom);
		write_reg(CFG_ENABLE, 32'($urandom_range(7) != 0));
	endtask

	// directed rows: expected typed in only when flagged
	typedef struct {
		logic signed [15:0] thr, yaw;
		logic [4:0] mflags;
		logic [1:0] rflags;
		logic typed;
		logic ok;
		logic [15:0] lon, steer;
	} row_t;

	row_t rows[] = '{
		'{16'sd16384, 16'sd16384, 5'h03, 2'h3, 1, 1, 16'd16384, 16'd16384},
		'{-16'sd16384, -16'sd16384, 5'h03, 2'h3, 1, 1, -16'd16384, -16'd16384},
		'{16'sd0, 16'sd0, 5'h03, 2'h3, 1, 1, 16'd0, 16'd0},
		'{16'sd16385, 16'sd0, 5'h03, 2'h3, 1, 0, 16'd0, 16'd0},
		'{16'sd0, -16'sd16385, 5'h03, 2'h3, 1, 0, 16'd0, 16'd0},
		'{16'sd32767, -16'sd32768, 5'h03, 2'h3, 1, 0, 16'd0, 16'd0},
		'{16'sd100, 16'sd100, 5'h07, 2'h3, 1, 0, 16'd0, 16'd0},
		'{16'sd100, 16'sd100, 5'h0B, 2'h3, 1, 0, 16'd0, 16'd0},
		'{16'sd100, 16'sd100, 5'h13, 2'h3, 1, 0, 16'd0, 16'd0},
		'{16'sd100, 16'sd100, 5'h01, 2'h3, 1, 0, 16'd0, 16'd0},
		'{16'sd100, 16'sd100, 5'h02, 2'h3, 1, 0, 16'd0, 16'd0},
		'{16'sd100, 16'sd100, 5'h03, 2'h1, 1, 0, 16'd0, 16'd0},
		'{16'sd100, 16'sd100, 5'h03, 2'h2, 1, 0, 16'd0, 16'd0},
		'{16'sd5000, 16'sd8192, 5'h03, 2'h3, 0, 0, 16'd0, 16'd0},
		'{-16'sd5000, -16'sd3000, 5'h03, 2'h3, 0, 0, 16'd0, 16'd0},
		'{16'sd1, 16'sd1, 5'h03, 2'h3, 0, 0, 16'd0, 16'd0}
	};

	initial begin
		snap_t x;
		dz_w = 0; expo_a = 0; sexpo_a = 0; gain = 0; tmo = 500000;
		enab = 0; manual_code = 0; rc_code = 1; seq_cnt = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// after reset everything gated off
		send_snap(good_snap(16'sd100, 16'sd100));
		drain();
		write_reg(CFG_ENABLE, 1);
		write_reg(CFG_GAIN, 32768);
		foreach (rows[i]) begin
			x = good_snap(rows[i].thr, rows[i].yaw);
			x.mflags = rows[i].mflags;
			x.rflags = rows[i].rflags;
			if (rows[i].typed) begin
				send_snap(x);
				if (pending_requests[$].ok !== rows[i].ok
					|| pending_requests[$].lon !== rows[i].lon
					|| pending_requests[$].steer !== rows[i].steer) begin
					$display("%0t row %0d exp ok=%0d lon=%0d steer=%0d", $time, i,
						rows[i].ok, $signed(rows[i].lon), $signed(rows[i].steer));
					errors++;
				end
			end else
				send_snap(x);
		end
		// timeout and time edges
		x = good_snap(16'sd0, 16'sd4000);
		x.mode_t = x.now_t - TW'(tmo);
		send_snap(x);
		x.mode_t = x.now_t - TW'(tmo) - 1;
		send_snap(x);
		x = good_snap(16'sd0, 16'sd4000);
		x.rc_sample_t = x.rc_t;
		x.rc_t = x.now_t;
		send_snap(x);
		drain();
		write_reg(8'd9, 32'hFFFF_FFFF);
		write_reg(CFG_DEADZONE, 32'hFFFF);
		write_reg(CFG_EXPO, 32'hFFFF);
		write_reg(CFG_SUPEREXPO, 32'hFFFF);
		write_reg(CFG_GAIN, 32'hFFFF);
		send_snap(good_snap(16'sd16384, 16'sd16384));
		send_snap(good_snap(16'sd16384, 16'sd16383));
		send_snap(good_snap(16'sd0, -16'sd16384));
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			snd_idle = ph < 4 ? 33 : ph < 8 ? 75 : 0;
			rcv_idle = ph < 4 ? 75 : ph < 8 ? 33 : 0;
			random_config();
			repeat (170) send_snap(random_snap());
			drain();
		end

		if (pending_requests.size() != 0) begin
			$display("%0t %0d transactions missing", $time, pending_requests.size());
			errors++;
		end
		if (errors == 0)
			$display("rc_stick_shaping_request_gate: match");
		else
			$display("rc_stick_shaping_request_gate: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
